/* rtl/gnms_pkg.sv */
package gnms_pkg;

	localparam int MAX_WIDTH_DEFAULT = 1024;
	localparam int MAG_BITS_DEFAULT  = 16;

	localparam int DIR_BITS    = 15;
	localparam int WIDTH_BITS  = 11;
	localparam int HEIGHT_BITS = 16;
	localparam int ROW_BITS    = 16;
	localparam int CFG_BITS    = 16;

	localparam logic [WIDTH_BITS-1:0]  FRAME_WIDTH_RESET  = 11'd640;
	localparam logic [HEIGHT_BITS-1:0] FRAME_HEIGHT_RESET = 16'd480;

	// result bundles queued between the compare stage and the output register
	localparam int BQ_DEPTH = 4;

	typedef enum logic [0:0] {
		CFG_FRAME_WIDTH  = 1'b0,
		CFG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		SEC_VERT    = 2'd0,
		SEC_DIAG_UR = 2'd1,
		SEC_HORZ    = 2'd2,
		SEC_DIAG_UL = 2'd3
	} sector_t;

	// lower bounds of the odd multiples of pi/8 from -9pi/8 to 9pi/8, Q3.12
	localparam logic signed [DIR_BITS-1:0] SECTOR_EDGE [10] = '{
		-15'sd14476, -15'sd11259, -15'sd8042, -15'sd4825, -15'sd1608,
		15'sd1609, 15'sd4826, 15'sd8043, 15'sd11260, 15'sd14477
	};

	function automatic sector_t quantize_sector(input logic signed [DIR_BITS-1:0] dir);
		logic [3:0] n;
		n = 4'd3;
		for (int i = 0; i < 10; i++) begin
			if (dir >= SECTOR_EDGE[i])
				n = n + 4'd1;
		end
		return sector_t'(n[1:0]);
	endfunction

endpackage

/* rtl/gnms_ram.sv */
module gnms_ram #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/gradient_non_maximum_suppression.sv */
// Channel   Direction  Handshake            Beat contents
// in        sink       in_valid / in_stall  magnitude, direction
// out       source     out_valid/ out_stall kept_magnitude, out_col, out_row, frame_done
// cfg       sink       cfg_valid/ cfg_ready cfg_index, cfg_data
//
// One pixel per clock enters while the output keeps up; the single output register
// moves one result per clock while out_stall is low, so rows that emit extra results
// (last column, last row) send them out one at a time. Line buffers sit in one RAM
// with a registered read. Reset clears counters, window and queue; the RAM needs no
// clearing pass.
// in_stall rises when the result queue cannot take one more pixel's results.
module gradient_non_maximum_suppression #(
	parameter int MAX_WIDTH = gnms_pkg::MAX_WIDTH_DEFAULT,
	parameter int MAG_BITS  = gnms_pkg::MAG_BITS_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [MAG_BITS-1:0]                  magnitude,
	input  logic signed [gnms_pkg::DIR_BITS-1:0] direction,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [MAG_BITS-1:0]                  kept_magnitude,
	output logic [$clog2(MAX_WIDTH)-1:0]         out_col,
	output logic [gnms_pkg::ROW_BITS-1:0]        out_row,
	output logic                                 frame_done,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [0:0]                           cfg_index,
	input  logic [gnms_pkg::CFG_BITS-1:0]        cfg_data
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int WW    = CW + 1;
	localparam int RW    = gnms_pkg::ROW_BITS;
	localparam int RAM_W = 2 * MAG_BITS + 2;
	localparam int QD    = gnms_pkg::BQ_DEPTH;
	localparam int QPW   = $clog2(QD);
	localparam int QCW   = $clog2(QD + 1);

	typedef struct packed {
		logic [MAG_BITS-1:0] kept;
		logic [CW-1:0]       col;
		logic [RW-1:0]       row;
		logic                done;
		logic [2:0]          flags;   // {last row zero, right edge zero, main result}
	} bundle_t;

	// configuration
	logic [gnms_pkg::WIDTH_BITS-1:0]  frame_width_q;
	logic [gnms_pkg::HEIGHT_BITS-1:0] frame_height_q;
	logic                             cfg_wr;
	logic [WW-1:0]                    w_eff;
	logic [CW-1:0]                    w_last;
	logic [RW-1:0]                    h_last;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= gnms_pkg::FRAME_WIDTH_RESET;
			frame_height_q <= gnms_pkg::FRAME_HEIGHT_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				gnms_pkg::CFG_FRAME_WIDTH:  frame_width_q <= cfg_data[gnms_pkg::WIDTH_BITS-1:0];
				gnms_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (frame_width_q < 11'd3)
			w_eff = WW'(3);
		else if (32'(frame_width_q) > 32'(MAX_WIDTH))
			w_eff = WW'(MAX_WIDTH);
		else
			w_eff = WW'(frame_width_q);
	end

	assign w_last = CW'(w_eff - WW'(1));
	assign h_last = (frame_height_q < 16'd3) ? RW'(2) : RW'(frame_height_q - 16'd1);

	// accept stage: raster counters and RAM read
	logic            in_acc;
	logic [CW-1:0]   col_q;
	logic [RW-1:0]   row_q;
	logic [QCW-1:0]  bq_count_q;
	logic            s1_valid_q;

	assign in_stall = ({1'b0, bq_count_q} + (QCW + 1)'(s1_valid_q)) >= (QCW + 1)'(QD);
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (col_q == w_last) begin
				col_q <= '0;
				row_q <= (row_q == h_last) ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	logic [MAG_BITS-1:0]  mag_s1;
	gnms_pkg::sector_t    sector_s1;
	logic [CW-1:0]        col_s1;
	logic [RW-1:0]        row_s1;
	logic                 main_s1, interior_s1, col_last_s1, row_last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else
			s1_valid_q <= in_acc;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mag_s1      <= magnitude;
			sector_s1   <= gnms_pkg::quantize_sector(direction);
			col_s1      <= col_q;
			row_s1      <= row_q;
			main_s1     <= (row_q != '0) && (col_q != '0);
			interior_s1 <= (row_q >= RW'(2)) && (col_q >= CW'(2));
			col_last_s1 <= col_q == w_last;
			row_last_s1 <= row_q == h_last;
		end
	end

	// line buffer RAM: {older row, newer row, sector of newer row}
	logic [RAM_W-1:0]    ram_rd;
	logic [MAG_BITS-1:0] older_rd, newer_rd;
	gnms_pkg::sector_t   sector_rd;

	gnms_ram #(
		.WIDTH(RAM_W),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk  (clk),
		.we   (s1_valid_q),
		.waddr(col_s1),
		.wdata({newer_rd, mag_s1, sector_s1}),
		.raddr(col_q),
		.rdata(ram_rd)
	);

	assign older_rd  = ram_rd[RAM_W-1 -: MAG_BITS];
	assign newer_rd  = ram_rd[MAG_BITS+1 -: MAG_BITS];
	assign sector_rd = gnms_pkg::sector_t'(ram_rd[1:0]);

	// compare stage: window columns 1 and 2, rows older/newer/current
	logic [MAG_BITS-1:0] win1_q [3];
	logic [MAG_BITS-1:0] win2_q [3];
	gnms_pkg::sector_t   sector_delay_q;
	logic [MAG_BITS-1:0] center, nb_a, nb_b, kept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				win1_q[i] <= '0;
				win2_q[i] <= '0;
			end
			sector_delay_q <= gnms_pkg::SEC_VERT;
		end else if (s1_valid_q) begin
			for (int i = 0; i < 3; i++)
				win1_q[i] <= win2_q[i];
			win2_q[0]      <= older_rd;
			win2_q[1]      <= newer_rd;
			win2_q[2]      <= mag_s1;
			sector_delay_q <= sector_rd;
		end
	end

	// neighbors as seen after this pixel shifts in
	always_comb begin
		center = win2_q[1];
		unique case (sector_delay_q)
			gnms_pkg::SEC_VERT: begin
				nb_a = win2_q[2];
				nb_b = win2_q[0];
			end
			gnms_pkg::SEC_DIAG_UR: begin
				nb_a = older_rd;
				nb_b = win1_q[2];
			end
			gnms_pkg::SEC_HORZ: begin
				nb_a = newer_rd;
				nb_b = win1_q[1];
			end
			default: begin
				nb_a = win1_q[0];
				nb_b = mag_s1;
			end
		endcase
		kept = (interior_s1 && center >= nb_a && center >= nb_b) ? center : '0;
	end

	// result bundle queue
	bundle_t        bq_q [QD];
	logic [QPW-1:0] bq_wr_q, bq_rd_q;
	bundle_t        push_b, head;
	logic           push, pop;

	assign push_b.kept  = kept;
	assign push_b.col   = col_s1;
	assign push_b.row   = row_s1;
	assign push_b.done  = col_last_s1;
	assign push_b.flags = {row_last_s1, main_s1 && col_last_s1, main_s1};
	assign push         = s1_valid_q && (main_s1 || row_last_s1);
	assign head         = bq_q[bq_rd_q];

	always_ff @(posedge clk) begin
		if (push)
			bq_q[bq_wr_q] <= push_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bq_wr_q    <= '0;
			bq_rd_q    <= '0;
			bq_count_q <= '0;
		end else begin
			if (push)
				bq_wr_q <= (bq_wr_q == QPW'(QD - 1)) ? '0 : bq_wr_q + QPW'(1);
			if (pop)
				bq_rd_q <= (bq_rd_q == QPW'(QD - 1)) ? '0 : bq_rd_q + QPW'(1);
			unique case ({push, pop})
				2'b10:   bq_count_q <= bq_count_q + QCW'(1);
				2'b01:   bq_count_q <= bq_count_q - QCW'(1);
				default: ;
			endcase
		end
	end

	// output register: unpack the head bundle, one result per beat
	logic [2:0]          sent_q, pending, pick;
	logic                out_load;
	logic                out_valid_q;
	logic [MAG_BITS-1:0] kept_q;
	logic [CW-1:0]       col_out_q;
	logic [RW-1:0]       row_out_q;
	logic                done_q;

	assign pending  = head.flags & ~sent_q;
	assign pick     = pending & (~pending + 3'd1);
	assign out_load = (bq_count_q != '0) && (!out_valid_q || !out_stall);
	assign pop      = out_load && ((pending & ~pick) == 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load)
				sent_q <= pop ? 3'd0 : (sent_q | pick);
			if (!out_valid_q || !out_stall)
				out_valid_q <= out_load;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			priority if (pick[0]) begin
				kept_q    <= head.kept;
				col_out_q <= head.col - CW'(1);
				row_out_q <= head.row - RW'(1);
				done_q    <= 1'b0;
			end else if (pick[1]) begin
				kept_q    <= '0;
				col_out_q <= head.col;
				row_out_q <= head.row - RW'(1);
				done_q    <= 1'b0;
			end else begin
				kept_q    <= '0;
				col_out_q <= head.col;
				row_out_q <= head.row;
				done_q    <= head.done;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign kept_magnitude = kept_q;
	assign out_col        = col_out_q;
	assign out_row        = row_out_q;
	assign frame_done     = done_q;

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(bq_count_q) <= QD)
		else $error("result queue overfilled");

	a_s1_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q |-> $past(in_acc))
		else $error("compare stage busy without an accepted pixel");

	a_done_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && done_q) |-> (kept_q == '0))
		else $error("frame end carries a nonzero magnitude");

	a_sent_subset: assert property (@(posedge clk) disable iff (!arst_n)
		(bq_count_q != '0) |-> ((sent_q & ~head.flags) == 3'd0))
		else $error("sent mask disagrees with head bundle");

endmodule

/* dv/tb_top.sv */
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_DEPTH   = 1024;
	localparam int DRAIN_CYCLES = 24;
	localparam int HOLD_CYCLES  = 300;

	// lower bounds of the odd multiples of pi/8 from -9pi/8 to 9pi/8, Q3.12
	localparam int PI8_BOUNDS [10] = '{
		-14476, -11259, -8042, -4825, -1608, 1609, 4826, 8043, 11260, 14477
	};

	typedef struct packed {
		logic [15:0] kept;
		logic [9:0]  col;
		logic [15:0] row;
		logic        done;
	} nms_pixel_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [15:0]        magnitude = '0;
	logic signed [14:0] direction = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [15:0]        kept_magnitude;
	logic [9:0]         out_col;
	logic [15:0]        out_row;
	logic               frame_done;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [0:0]         cfg_index = '0;
	logic [15:0]        cfg_data = '0;

	// shadow of the block
	logic [10:0]       geom_width;
	logic [15:0]       geom_height;
	logic [15:0]       line_prev2 [LINE_DEPTH];
	logic [15:0]       line_prev1 [LINE_DEPTH];
	gnms_pkg::sector_t line_sector [LINE_DEPTH];
	logic [15:0]       win [3][3];
	gnms_pkg::sector_t pending_sector;
	int                pix_col;
	int                pix_row;

	nms_pixel_t expected_pixels [$];
	nms_pixel_t want;

	int errors = 0;
	int pixels_sent = 0;
	int results_checked = 0;
	int reg_writes = 0;
	int input_held_cycles = 0;
	int send_idle_pct = 34;
	int recv_idle_pct = 67;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;

	always #4 clk = ~clk;

	gradient_non_maximum_suppression u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.magnitude      (magnitude),
		.direction      (direction),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kept_magnitude (kept_magnitude),
		.out_col        (out_col),
		.out_row        (out_row),
		.frame_done     (frame_done),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	function automatic gnms_pkg::sector_t dir_to_sector(input logic signed [14:0] dir);
		int angle;
		int bin;
		angle = dir;
		bin = 3;
		for (int i = 0; i < 10; i++) begin
			if (angle >= PI8_BOUNDS[i])
				bin++;
		end
		return gnms_pkg::sector_t'(bin % 4);
	endfunction

	function automatic logic [15:0] rand_magnitude();
		case ($urandom_range(0, 3))
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 3));
			2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			default: return 16'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic signed [14:0] rand_direction();
		case ($urandom_range(0, 9))
			0, 1: return 15'($urandom);
			2: return 15'(PI8_BOUNDS[$urandom_range(0, 9)] + int'($urandom_range(0, 2)) - 1);
			default: return 15'(int'($urandom_range(0, 25736)) - 12868);
		endcase
	endfunction

	task automatic reset_shadow();
		geom_width = gnms_pkg::FRAME_WIDTH_RESET;
		geom_height = gnms_pkg::FRAME_HEIGHT_RESET;
		for (int i = 0; i < LINE_DEPTH; i++) begin
			line_prev2[i] = '0;
			line_prev1[i] = '0;
			line_sector[i] = gnms_pkg::SEC_VERT;
		end
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				win[i][j] = '0;
		pending_sector = gnms_pkg::SEC_VERT;
		pix_col = 0;
		pix_row = 0;
	endtask

	task automatic expect_pixel(input logic [15:0] kept, input int col, input int row,
			input logic done);
		expected_pixels.push_back('{kept: kept, col: 10'(col), row: 16'(row), done: done});
	endtask

	// advance the shadow by one pixel and queue the results it releases
	task automatic suppress_pixel(input logic [15:0] mag, input logic signed [14:0] dir);
		int w;
		int h;
		int c;
		int r;
		logic [15:0] n_a;
		logic [15:0] n_b;
		logic [15:0] kept;
		gnms_pkg::sector_t ctr_sec;
		w = (geom_width < 3) ? 3 : int'(geom_width);
		if (w > LINE_DEPTH)
			w = LINE_DEPTH;
		h = (geom_height < 3) ? 3 : int'(geom_height);
		if (pix_col >= w)
			pix_col = 0;
		if (pix_row >= h)
			pix_row = 0;
		c = pix_col;
		r = pix_row;
		for (int i = 0; i < 3; i++) begin
			win[i][0] = win[i][1];
			win[i][1] = win[i][2];
		end
		win[0][2] = line_prev2[c];
		win[1][2] = line_prev1[c];
		win[2][2] = mag;
		line_prev2[c] = line_prev1[c];
		line_prev1[c] = mag;
		ctr_sec = pending_sector;
		pending_sector = line_sector[c];
		line_sector[c] = dir_to_sector(dir);

		if (r >= 1 && c >= 1) begin
			kept = '0;
			if (r >= 2 && c >= 2) begin
				case (ctr_sec)
					gnms_pkg::SEC_VERT: begin
						n_a = win[2][1];
						n_b = win[0][1];
					end
					gnms_pkg::SEC_DIAG_UR: begin
						n_a = win[0][2];
						n_b = win[2][0];
					end
					gnms_pkg::SEC_HORZ: begin
						n_a = win[1][2];
						n_b = win[1][0];
					end
					default: begin
						n_a = win[0][0];
						n_b = win[2][2];
					end
				endcase
				if (win[1][1] >= n_a && win[1][1] >= n_b)
					kept = win[1][1];
			end
			expect_pixel(kept, c - 1, r - 1, 1'b0);
			if (c == w - 1)
				expect_pixel('0, c, r - 1, 1'b0);
		end
		if (r == h - 1)
			expect_pixel('0, c, r, (c == w - 1));

		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h)
				r = 0;
		end
		pix_col = c;
		pix_row = r;
	endtask

	task automatic send_pixel(input logic [15:0] mag, input logic signed [14:0] dir);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		magnitude <= mag;
		direction <= dir;
		do @(posedge clk); while (in_stall);
		suppress_pixel(mag, dir);
		pixels_sent++;
	endtask

	// drop valid, then let every queued result drain, then wait out the DRAIN_CYCLES slack
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input gnms_pkg::cfg_reg_t idx, input logic [15:0] data);
		wait_idle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == gnms_pkg::CFG_FRAME_WIDTH)
			geom_width = data[10:0];
		else
			geom_height = data;
		pix_col = 0;
		pix_row = 0;
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_random(input int count);
		for (int i = 0; i < count; i++)
			send_pixel(rand_magnitude(), rand_direction());
	endtask

	// out of reset the geometry is 640 x 480: the start of row 0 releases nothing
	task automatic test_reset_geometry();
		send_random(24);
	endtask

	// 5 x 4 frame: sector boundaries in both directions, every sector at the center,
	// magnitude extremes and ties
	task automatic test_directed_sectors();
		logic [15:0] mags [20];
		logic signed [14:0] dirs [20];
		mags = '{16'd5, 16'd65535, 16'd0, 16'd7, 16'd3,
			16'd9, 16'd100, 16'd100, 16'd65535, 16'd2,
			16'd7, 16'd100, 16'd50, 16'd100, 16'd1,
			16'd0, 16'd100, 16'd7, 16'd8, 16'd65535};
		dirs = '{-15'sd16384, 15'sd16383, -15'sd14477, -15'sd14476, -15'sd11260,
			-15'sd11259, 15'sd1608, 15'sd1609, 15'sd4825, -15'sd8043,
			-15'sd8042, 15'sd4826, 15'sd8043, 15'sd14477, -15'sd4826,
			-15'sd4825, -15'sd1609, -15'sd1608, 15'sd11260, 15'sd14476};
		write_reg(gnms_pkg::CFG_FRAME_WIDTH, 16'd5);
		write_reg(gnms_pkg::CFG_FRAME_HEIGHT, 16'd4);
		for (int i = 0; i < 20; i++)
			send_pixel(mags[i], dirs[i]);
	endtask

	// geometry below the minimum and the tallest frame
	task automatic test_clamped_geometry();
		write_reg(gnms_pkg::CFG_FRAME_WIDTH, 16'd0);
		write_reg(gnms_pkg::CFG_FRAME_HEIGHT, 16'd1);
		send_random(18);
		write_reg(gnms_pkg::CFG_FRAME_WIDTH, 16'd2);
		write_reg(gnms_pkg::CFG_FRAME_HEIGHT, 16'd2);
		send_random(12);
		write_reg(gnms_pkg::CFG_FRAME_WIDTH, 16'd3);
		write_reg(gnms_pkg::CFG_FRAME_HEIGHT, 16'hFFFF);
		send_random(15);
	endtask

	// a width beyond the line buffers acts as the widest row: row 0 releases nothing
	task automatic test_wide_rows();
		write_reg(gnms_pkg::CFG_FRAME_WIDTH, 16'hFFFF);
		write_reg(gnms_pkg::CFG_FRAME_HEIGHT, 16'd3);
		send_random(24);
	endtask

	// hold the output off for a long stretch while pixels keep coming
	task automatic test_output_backpressure();
		int saved_idle;
		saved_idle = send_idle_pct;
		write_reg(gnms_pkg::CFG_FRAME_WIDTH, 16'd6);
		write_reg(gnms_pkg::CFG_FRAME_HEIGHT, 16'd5);
		send_idle_pct = 0;
		hold_req++;
		send_random(48);
		send_idle_pct = saved_idle;
	endtask

	task automatic test_random_frames();
		int sent;
		int w;
		int h;
		int count;
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					send_idle_pct = 34;
					recv_idle_pct = 67;
				end
				1: begin
					send_idle_pct = 67;
					recv_idle_pct = 34;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			sent = 0;
			while (sent < 50) begin
				case ($urandom_range(0, 9))
					0: w = $urandom_range(0, 2);
					1, 2: w = $urandom_range(9, 16);
					default: w = $urandom_range(3, 8);
				endcase
				case ($urandom_range(0, 9))
					0: h = $urandom_range(0, 2);
					1: h = $urandom_range(7, 65535);
					default: h = $urandom_range(3, 6);
				endcase
				// now and then keep one register and let the write restart mid-frame
				if ($urandom_range(0, 3) != 0)
					write_reg(gnms_pkg::CFG_FRAME_WIDTH, 16'(w));
				else
					w = geom_width;
				write_reg(gnms_pkg::CFG_FRAME_HEIGHT, 16'(h));
				w = (w < 3) ? 3 : ((w > LINE_DEPTH) ? LINE_DEPTH : w);
				h = (h < 3) ? 3 : h;
				if (w * h <= 30 && $urandom_range(0, 2) != 0)
					count = w * h * $urandom_range(1, 2);
				else
					count = $urandom_range(w + 2, (3 * w < 60) ? 60 : 3 * w);
				send_random(count);
				sent += count;
			end
		end
	endtask

	// output side: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_pixels.size() == 0) begin
				$error("result with nothing pending: col %0d row %0d kept %0d",
					out_col, out_row, kept_magnitude);
				errors++;
			end else begin
				want = expected_pixels.pop_front();
				results_checked++;
				if (kept_magnitude !== want.kept) begin
					$error("kept_magnitude: expected %0d, got %0d", want.kept, kept_magnitude);
					errors++;
				end
				if (out_col !== want.col) begin
					$error("out_col: expected %0d, got %0d", want.col, out_col);
					errors++;
				end
				if (out_row !== want.row) begin
					$error("out_row: expected %0d, got %0d", want.row, out_row);
					errors++;
				end
				if (frame_done !== want.done) begin
					$error("frame_done: expected %0d, got %0d", want.done, frame_done);
					errors++;
				end
			end
		end
		if (in_valid && in_stall)
			input_held_cycles++;
	end

	initial begin
		#3_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		reset_shadow();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_geometry();
		test_directed_sectors();
		test_clamped_geometry();
		test_wide_rows();
		test_output_backpressure();
		test_random_frames();

		wait_idle();
		if (expected_pixels.size() != 0) begin
			$error("%0d results never arrived", expected_pixels.size());
			errors++;
		end
		$display("tb: %0d pixels in, %0d results compared, %0d register writes",
			pixels_sent, results_checked, reg_writes);
		$display("tb: input held off by the block for %0d cycles, %0d mismatches",
			input_held_cycles, errors);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
